// ===== hdl/chs_pkg.sv =====
// Package for the cosine hemisphere sampler: constants, arctangent table, helpers.
// No dependencies.
`timescale 1ns / 1ps
package chs_pkg;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam logic [31:0] PI4_Q30         = 32'd843314857;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] INV_PI_Q32      = 32'd1367130551;

    // Arctangent of 2^-i in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] t [ATAN_ENTRIES];
        t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
              32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
              32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
              32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
              32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};
        return t[i];
    endfunction
endpackage

// ===== hdl/chs_divider.sv =====
// Pipelined restoring divider: q = floor((num << FB) / den), one quotient bit a stage.
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_divider
    import chs_pkg::*;
#(
    parameter int FB = FRAC_BITS_DEF,
    parameter int W  = 17,
    parameter int TW = 1
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [W-1:0]    num,
    input  logic [W-1:0]    den,
    input  logic [TW-1:0]   in_tag,
    output logic            out_valid,
    output logic [FB:0]     quot,
    output logic [TW-1:0]   out_tag
);
    // num <= den, so quotient fits FB+1 bits; remainder always < den
    localparam int RW = W + 1;
    localparam int NS = FB + 1;

    logic              v_reg   [NS+1];
    logic [RW-1:0]     rem_reg [NS+1];
    logic [W-1:0]      den_reg [NS+1];
    logic [FB:0]       q_reg   [NS+1];
    logic [TW-1:0]     tag_reg [NS+1];

    assign rem_reg[0] = {1'b0, num};
    assign den_reg[0] = den;
    assign q_reg[0]   = '0;
    assign tag_reg[0] = in_tag;
    assign v_reg[0]   = in_valid;

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [RW-1:0] rem_next;
        logic [FB:0]   q_next;
        logic          ge;
        // first stage compares num itself, later ones the doubled remainder
        always_comb
        begin
            logic [RW-1:0] cand;
            cand = (s == 0) ? rem_reg[s] : {rem_reg[s][RW-2:0], 1'b0};
            ge = cand >= {1'b0, den_reg[s]};
            rem_next = ge ? cand - {1'b0, den_reg[s]} : cand;
            q_next = {q_reg[s][FB-1:0], ge};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= rem_next;
            den_reg[s+1] <= den_reg[s];
            q_reg[s+1]   <= q_next;
            tag_reg[s+1] <= tag_reg[s];
        end
    end

    assign out_valid = v_reg[NS];
    assign quot      = q_reg[NS];
    assign out_tag   = tag_reg[NS];
endmodule

// ===== hdl/chs_cordic.sv =====
// Pipelined rotation-mode CORDIC, Q2.30, one micro-rotation a stage; outputs clamped to [0,1].
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_cordic
    import chs_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int TW     = 1
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [31:0]    theta,
    input  logic [TW-1:0]  in_tag,
    output logic           out_valid,
    output logic [30:0]    cos_q30,
    output logic [30:0]    sin_q30,
    output logic [TW-1:0]  out_tag
);
    localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

    logic               v_reg [N+2];
    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic [TW-1:0]      tag_reg [N+2];
    logic [30:0]        c_reg, s_reg;

    assign v_reg[0]   = in_valid;
    assign x_reg[0]   = 34'(CORDIC_GAIN_Q30);
    assign y_reg[0]   = '0;
    assign z_reg[0]   = $signed({2'b00, theta});
    assign tag_reg[0] = in_tag;

    for (genvar i = 0; i < N; i++) begin : g_st
        // arithmetic shift is a floor shift
        logic signed [33:0] dx, dy, at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = 34'(atan_q30(i));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][33])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + at;
            end
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    function automatic logic [30:0] clamp1(input logic signed [33:0] v);
        if (v < 0)
            return '0;
        if (v > 34'sd1073741824)
            return 31'd1073741824;
        return v[30:0];
    endfunction

    // clamp stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[N+1] <= 1'b0;
        else
            v_reg[N+1] <= v_reg[N];
    end
    always_ff @(posedge clk)
    begin
        c_reg <= clamp1(x_reg[N]);
        s_reg <= clamp1(y_reg[N]);
        tag_reg[N+1] <= tag_reg[N];
    end

    assign out_valid = v_reg[N+1];
    assign cos_q30   = c_reg;
    assign sin_q30   = s_reg;
    assign out_tag   = tag_reg[N+1];
endmodule

// ===== hdl/chs_sqrt.sv =====
// Pipelined integer square root, one result bit a stage.
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_sqrt
    import chs_pkg::*;
#(
    parameter int RB = 16,
    parameter int TW = 1
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2*RB-1:0] radicand,
    input  logic [TW-1:0]  in_tag,
    output logic           out_valid,
    output logic [RB-1:0]  root,
    output logic [TW-1:0]  out_tag
);
    localparam int VW = 2 * RB;
    logic              v_reg   [RB+1];
    logic [VW-1:0]     rad_reg [RB+1];
    logic [RB+1:0]     rem_reg [RB+1];
    logic [RB-1:0]     res_reg [RB+1];
    logic [TW-1:0]     tag_reg [RB+1];

    assign v_reg[0]   = in_valid;
    assign rad_reg[0] = radicand;
    assign rem_reg[0] = '0;
    assign res_reg[0] = '0;
    assign tag_reg[0] = in_tag;

    // digit-by-digit: bring down two bits, try 4*res+1
    for (genvar i = 0; i < RB; i++) begin : g_st
        logic [RB+1:0] cur, trial;
        logic          ok;
        assign cur   = {rem_reg[i][RB-1:0], rad_reg[i][VW-1 -: 2]};
        assign trial = {res_reg[i], 2'b01};
        assign ok    = cur >= trial;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            rad_reg[i+1] <= {rad_reg[i][VW-3:0], 2'b00};
            rem_reg[i+1] <= ok ? cur - trial : cur;
            res_reg[i+1] <= {res_reg[i][RB-2:0], ok};
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_valid = v_reg[RB];
    assign root      = res_reg[RB];
    assign out_tag   = tag_reg[RB];
endmodule

// ===== hdl/cosine_hemisphere_sampler_core.sv =====
// Cosine-weighted hemisphere sampler (concentric disc map), fully pipelined.
// Throughput: one item per cycle; busy is held low, start is always taken.
// Pipeline order: magnitudes, divider, angle, CORDIC, radius scale, axes and squares,
//   1 - p^2, square root, signs and pdf, output registers.
// Reset: rst_n asynchronous, clears all valid bits; receiver cannot stall.
// Depends on chs_pkg, chs_divider, chs_cordic, chs_sqrt.
`timescale 1ns / 1ps
module cosine_hemisphere_sampler_core
    import chs_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        rand_a,
    input  logic [15:0]        rand_b,
    output logic               done,
    output logic signed [15:0] dir_x,
    output logic [14:0]        dir_y,
    output logic signed [15:0] dir_z,
    output logic [14:0]        pdf
);
    localparam int FB = FRAC_BITS;
    localparam int RW = FB + 1;          // radius width, R <= 2^FB
    // tag: neg_a, neg_b, a_larger, radius
    localparam int TW = 3 + RW;
    localparam int PW = FB + 1;          // disc magnitude width
    localparam int SW = 2 * PW + 1;      // sum of squares

    typedef struct packed {
        logic          neg_a;
        logic          neg_b;
        logic          a_larger;
        logic [RW-1:0] r;
    } tag_t;

    assign busy = 1'b0;

    // stage 1: magnitudes and ordering
    logic        v1_reg;
    logic [16:0] mx_reg, mn_reg;
    tag_t        t1_reg;
    logic [16:0] t1_next_mx, t1_next_mn;
    tag_t        t1_next;
    always_comb
    begin
        logic signed [17:0] a, b;
        logic [16:0] ma, mb;
        logic al;
        a = $signed({1'b0, rand_a, 1'b0}) - 18'sd65536;
        b = $signed({1'b0, rand_b, 1'b0}) - 18'sd65536;
        ma = a[17] ? 17'(-a) : a[16:0];
        mb = b[17] ? 17'(-b) : b[16:0];
        al = ma > mb;
        t1_next_mx = al ? ma : mb;
        t1_next_mn = al ? mb : ma;
        t1_next.neg_a = a[17];
        t1_next.neg_b = b[17];
        t1_next.a_larger = al;
        t1_next.r = RW'(({{FB{1'b0}}, t1_next_mx} << FB) >> 16);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        // at the centre mx=0: divide by 1 gives t=0 and r=0, so disc is (0,0)
        mx_reg <= (t1_next_mx == '0) ? 17'd1 : t1_next_mx;
        mn_reg <= t1_next_mn;
        t1_reg <= t1_next;
    end

    // ratio t = mn/mx
    logic          v2;
    logic [FB:0]   tq;
    logic [TW-1:0] t2;
    chs_divider #(.FB(FB), .W(17), .TW(TW)) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg), .num(mn_reg), .den(mx_reg),
        .in_tag(t1_reg), .out_valid(v2), .quot(tq), .out_tag(t2));

    // stage: angle = pi/4 * t
    logic        v3_reg;
    logic [31:0] th_reg;
    tag_t        t3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2;
    end
    always_ff @(posedge clk)
    begin
        th_reg <= 32'((64'(PI4_Q30) * 64'(tq)) >> FB);
        t3_reg <= t2;
    end

    logic          v4;
    logic [30:0]   cq, sq;
    logic [TW-1:0] t4;
    chs_cordic #(.STAGES(CORDIC_STAGES), .TW(TW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .in_valid(v3_reg), .theta(th_reg), .in_tag(t3_reg),
        .out_valid(v4), .cos_q30(cq), .sin_q30(sq), .out_tag(t4));

    // scale by radius
    logic        v5_reg;
    logic [PW-1:0] rc_reg, rs_reg;
    tag_t        t5_reg;
    tag_t        t4s;
    assign t4s = t4;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4;
    end
    always_ff @(posedge clk)
    begin
        rc_reg <= PW'((64'(t4s.r) * 64'(cq)) >> 30);
        rs_reg <= PW'((64'(t4s.r) * 64'(sq)) >> 30);
        t5_reg <= t4;
    end

    // assign axes, square
    logic          v6_reg;
    logic [PW-1:0] px_reg, pz_reg;
    logic [SW-1:0] sx_reg, sz_reg;
    tag_t          t6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        px_reg <= t5_reg.a_larger ? rc_reg : rs_reg;
        pz_reg <= t5_reg.a_larger ? rs_reg : rc_reg;
        sx_reg <= t5_reg.a_larger ? SW'(rc_reg) * SW'(rc_reg) : SW'(rs_reg) * SW'(rs_reg);
        sz_reg <= t5_reg.a_larger ? SW'(rs_reg) * SW'(rs_reg) : SW'(rc_reg) * SW'(rc_reg);
        t6_reg <= t5_reg;
    end

    // 1 - p^2 scaled to Q30
    logic          v7_reg;
    logic [31:0]   big_reg;
    logic [PW-1:0] px7_reg, pz7_reg;
    tag_t          t7_reg;
    logic [31:0]   big_next;
    always_comb
    begin
        logic [SW:0] s, one2, d;
        s = {1'b0, sx_reg} + {1'b0, sz_reg};
        one2 = (SW+1)'(1) << (2 * FB);
        d = (s >= one2) ? '0 : one2 - s;
        if (2 * FB <= 30)
            big_next = 32'(64'(d) << (30 - 2 * FB));
        else
            big_next = 32'(64'(d) >> (2 * FB - 30));
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        big_reg <= big_next;
        px7_reg <= px_reg;
        pz7_reg <= pz_reg;
        t7_reg <= t6_reg;
    end

    // pack px, pz, signs through the root pipeline
    localparam int QT = 2 + 2 * PW;
    logic          v8;
    logic [15:0]   root;
    logic [QT-1:0] q8;
    chs_sqrt #(.RB(16), .TW(QT)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(v7_reg), .radicand(big_reg),
        .in_tag({t7_reg.neg_a, t7_reg.neg_b, px7_reg, pz7_reg}),
        .out_valid(v8), .root(root), .out_tag(q8));

    // wide enough for the left shift when FB is below 15
    localparam int QW = PW + 16;

    function automatic logic [15:0] to_s16(input logic [PW-1:0] m, input logic neg);
        logic [QW-1:0] q;
        if (FB > 15)
            q = (QW'(m) + (QW'(1) << (FB - 16))) >> (FB - 15);
        else
            q = QW'(m) << (15 - FB);
        if (neg)
        begin
            if (q > 32768)
                q = QW'(32768);
            return 16'(17'h10000 - 17'(q));
        end
        if (q > 32767)
            q = QW'(32767);
        return 16'(q);
    endfunction

    // output: signs, rounding, pdf multiply
    logic        v9_reg;
    logic [15:0] x9_reg, z9_reg;
    logic [14:0] y9_reg;
    logic [47:0] pp_reg;
    logic [14:0] y15;
    assign y15 = root[15] ? 15'd32767 : root[14:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= v8;
    end
    always_ff @(posedge clk)
    begin
        x9_reg <= to_s16(q8[2*PW-1:PW], q8[QT-1]);
        z9_reg <= to_s16(q8[PW-1:0], q8[QT-2]);
        y9_reg <= y15;
        pp_reg <= 48'(y15) * 48'(INV_PI_Q32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v9_reg;
    end
    always_ff @(posedge clk)
    begin
        dir_x <= x9_reg;
        dir_z <= z9_reg;
        dir_y <= y9_reg;
        pdf   <= 15'(({pp_reg, 1'b0} + 49'(33'h80000000)) >> 32);
    end
endmodule
